// File: src/gcle_pkg.sv
// Package with the shared constants and types of the context line emitter.
package gcle_pkg;

  localparam int MAX_BEFORE = 8;
  localparam int OFF_W = 48;
  localparam int LINE_W = 32;
  localparam int LEN_W = 24;
  localparam int BEF_W = 4;
  localparam int AFT_W = 16;
  localparam int CFG_W = 16;
  localparam int DEPTH_W = $clog2(MAX_BEFORE + 1);

  localparam logic REG_BEFORE = 1'b0;
  localparam logic REG_AFTER = 1'b1;

  localparam logic ROLE_MATCH = 1'b0;
  localparam logic ROLE_CONTEXT = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [LINE_W-1:0] line;
    logic [OFF_W-1:0]  start;
    logic [OFF_W-1:0]  stop;
    logic [LEN_W-1:0]  width;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic keep;
  } cell_ctrl_t;

  typedef struct packed {
    logic              role;
    logic [LINE_W-1:0] line_index;
    logic [OFF_W-1:0]  line_start;
    logic [OFF_W-1:0]  line_stop;
    logic [LEN_W-1:0]  line_width;
    logic              last;
  } record_t;

endpackage

// File: src/gcle_cell.sv
// One cell of the ring chain, holding a single remembered line.
module gcle_cell
  import gcle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  entry_t     prev,
  output entry_t     entry
);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (ctrl.clear) begin
      entry.valid <= 1'b0;
    end else if (ctrl.shift) begin
      entry.valid <= prev.valid && ctrl.keep;
    end
    if (ctrl.shift) begin
      entry.line <= prev.line;
      entry.start <= prev.start;
      entry.stop <= prev.stop;
      entry.width <= prev.width;
    end
  end

endmodule

// File: src/gcle_out.sv
// Output register that holds one record until the consumer takes the beat.
module gcle_out
  import gcle_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  record_t           rec,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              role,
  output logic [LINE_W-1:0] line_index,
  output logic [OFF_W-1:0]  line_start,
  output logic [OFF_W-1:0]  line_stop,
  output logic [LEN_W-1:0]  line_width,
  output logic              last
);

  record_t held;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= rec;
    end
  end

  assign role = held.role;
  assign line_index = held.line_index;
  assign line_start = held.line_start;
  assign line_stop = held.line_stop;
  assign line_width = held.line_width;
  assign last = held.last;

endmodule

// File: src/grep_context_line_emitter.sv
// Top level of the grep-style context line emitter.
// Each input beat is one finished text line; the block numbers it, works out its start
// offset and emits match and context records in ascending line order. Recent non-matching
// lines live in a chain of cells, newest in the first cell; inserting a line shifts the
// chain by one and drops entries beyond the before depth. A non-matching line passes from
// S_IDLE through S_DECIDE, and S_EMIT too when it goes out as context; a match passes
// through S_DECIDE, S_FLUSH and S_EMIT. S_FLUSH shifts the chain one cell a cycle, unless
// the output register is full, until its newest entry has left the last cell, handing at
// most one entry a cycle to the output register. Lines are taken only in S_IDLE.
// Records stall only when the output register is still full.
module grep_context_line_emitter
  import gcle_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              new_file,
  input  logic              is_match,
  input  logic [OFF_W-1:0]  line_end,
  input  logic [LEN_W-1:0]  line_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              role,
  output logic [LINE_W-1:0] line_index,
  output logic [OFF_W-1:0]  line_start,
  output logic [OFF_W-1:0]  line_stop,
  output logic [LEN_W-1:0]  line_width,
  output logic              last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_FLUSH,
    S_EMIT
  } state_t;

  state_t state;

  logic [BEF_W-1:0]   before_lines;
  logic [AFT_W-1:0]   after_lines;
  logic [AFT_W-1:0]   after_left;
  logic [LINE_W-1:0]  line_counter;
  logic [LINE_W-1:0]  last_emitted;
  logic               emitted_any;
  logic [OFF_W-1:0]   current_start;
  logic               hold_match;
  logic [OFF_W-1:0]   hold_stop;
  logic [LEN_W-1:0]   hold_width;

  logic [DEPTH_W-1:0] depth;
  logic               fresh;
  logic               top_fresh;
  logic               any_valid;
  logic               out_free;
  logic               out_load;
  record_t            out_rec;
  logic               cell_clear;
  logic               cell_shift;
  logic               insert_mode;
  entry_t             head;
  entry_t             chain [MAX_BEFORE];
  logic [MAX_BEFORE-1:0] valid_bits;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      before_lines <= '0;
      after_lines <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BEFORE: before_lines <= cfg_data[BEF_W-1:0];
        REG_AFTER:  after_lines <= cfg_data[AFT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (int'(before_lines) > MAX_BEFORE) begin
      depth = DEPTH_W'(MAX_BEFORE);
    end else begin
      depth = DEPTH_W'(before_lines);
    end
  end

  assign fresh = !emitted_any || (line_counter > last_emitted);
  assign top_fresh = !emitted_any || (chain[MAX_BEFORE-1].line > last_emitted);
  assign any_valid = |valid_bits;

  always_comb begin
    cell_clear = 1'b0;
    cell_shift = 1'b0;
    insert_mode = 1'b0;
    out_load = 1'b0;
    out_rec.role = hold_match ? ROLE_MATCH : ROLE_CONTEXT;
    out_rec.line_index = line_counter;
    out_rec.line_start = current_start;
    out_rec.line_stop = hold_stop;
    out_rec.line_width = hold_width;
    out_rec.last = 1'b1;
    unique case (state)
      S_IDLE: begin
        cell_clear = in_valid && new_file;
      end
      S_DECIDE: begin
        if (!hold_match && depth != '0) begin
          cell_shift = 1'b1;
          insert_mode = 1'b1;
        end
      end
      S_FLUSH: begin
        if (any_valid) begin
          if (chain[MAX_BEFORE-1].valid && top_fresh) begin
            if (out_free) begin
              out_load = 1'b1;
              cell_shift = 1'b1;
            end
          end else begin
            cell_shift = 1'b1;
          end
        end
        out_rec.role = ROLE_CONTEXT;
        out_rec.line_index = chain[MAX_BEFORE-1].line;
        out_rec.line_start = chain[MAX_BEFORE-1].start;
        out_rec.line_stop = chain[MAX_BEFORE-1].stop;
        out_rec.line_width = chain[MAX_BEFORE-1].width;
        out_rec.last = 1'b0;
      end
      S_EMIT: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    head.valid = insert_mode;
    head.line = line_counter;
    head.start = current_start;
    head.stop = hold_stop;
    head.width = hold_width;
  end

  for (genvar k = 0; k < MAX_BEFORE; k++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     prev;

    assign ctrl.clear = cell_clear;
    assign ctrl.shift = cell_shift;
    assign ctrl.keep = !insert_mode || (DEPTH_W'(k) < depth);
    assign valid_bits[k] = chain[k].valid;

    if (k == 0) begin : g_head
      assign prev = head;
    end else begin : g_link
      assign prev = chain[k-1];
    end

    gcle_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .prev  (prev),
      .entry (chain[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      after_left <= '0;
      line_counter <= '0;
      last_emitted <= '0;
      emitted_any <= 1'b0;
      current_start <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            hold_match <= is_match;
            hold_stop <= line_end;
            hold_width <= line_length;
            if (new_file) begin
              after_left <= '0;
              line_counter <= '0;
              last_emitted <= '0;
              emitted_any <= 1'b0;
              current_start <= '0;
            end
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (hold_match) begin
            after_left <= after_lines;
            state <= S_FLUSH;
          end else if (after_left != '0 && fresh) begin
            after_left <= after_left - AFT_W'(1);
            state <= S_EMIT;
          end else begin
            if (after_left != '0) begin
              after_left <= after_left - AFT_W'(1);
            end
            line_counter <= line_counter + LINE_W'(1);
            current_start <= hold_stop;
            state <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (out_load) begin
            last_emitted <= chain[MAX_BEFORE-1].line;
            emitted_any <= 1'b1;
          end
          if (!any_valid) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            last_emitted <= line_counter;
            emitted_any <= 1'b1;
            line_counter <= line_counter + LINE_W'(1);
            current_start <= hold_stop;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  gcle_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (out_load),
    .rec        (out_rec),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .role       (role),
    .line_index (line_index),
    .line_start (line_start),
    .line_stop  (line_stop),
    .line_width (line_width),
    .last       (last)
  );

endmodule

// File: dv/gcle_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard class that predicts and checks the records of the context line emitter.
package gcle_tb_pkg;
  import gcle_pkg::*;

  class context_scoreboard;
    logic [BEF_W-1:0]  before_setting;
    logic [AFT_W-1:0]  after_setting;
    logic [OFF_W-1:0]  held_start [MAX_BEFORE];
    logic [OFF_W-1:0]  held_stop [MAX_BEFORE];
    logic [LINE_W-1:0] held_line [MAX_BEFORE];
    logic [LEN_W-1:0]  held_width [MAX_BEFORE];
    int unsigned       held_count;
    logic [AFT_W-1:0]  after_left;
    logic [LINE_W-1:0] newest_out;
    bit                any_out;
    logic [LINE_W-1:0] line_no;
    logic [OFF_W-1:0]  next_start;
    record_t           expected_records [$];
    int unsigned       mismatches;

    function new();
      before_setting = '0;
      after_setting = '0;
      mismatches = 0;
      restart_file();
    endfunction

    function void restart_file();
      held_count = 0;
      after_left = '0;
      newest_out = '0;
      any_out = 1'b0;
      line_no = '0;
      next_start = '0;
    endfunction

    function void set_register(logic index, logic [CFG_W-1:0] data);
      if (index == REG_BEFORE) begin
        before_setting = data[BEF_W-1:0];
      end else begin
        after_setting = data[AFT_W-1:0];
      end
    endfunction

    function bit is_fresh(logic [LINE_W-1:0] line);
      return !any_out || line > newest_out;
    endfunction

    function void add_record(logic r, logic [LINE_W-1:0] line, logic [OFF_W-1:0] start,
                             logic [OFF_W-1:0] stop, logic [LEN_W-1:0] width);
      record_t rec;
      rec.role = r;
      rec.line_index = line;
      rec.line_start = start;
      rec.line_stop = stop;
      rec.line_width = width;
      rec.last = 1'b0;
      expected_records = {expected_records, rec};
      newest_out = line;
      any_out = 1'b1;
    endfunction

    // Works out the records caused by one accepted line and queues them in order.
    function void note_line(logic nf, logic m, logic [OFF_W-1:0] stop,
                            logic [LEN_W-1:0] width);
      int unsigned depth;
      int unsigned first;
      int unsigned i;
      logic [OFF_W-1:0] start;
      record_t tail;
      if (nf) restart_file();
      first = expected_records.size();
      depth = (before_setting > MAX_BEFORE) ? MAX_BEFORE : before_setting;
      start = next_start;
      if (m) begin
        for (i = 0; i < held_count; i++) begin
          if (is_fresh(held_line[i])) begin
            add_record(ROLE_CONTEXT, held_line[i], held_start[i], held_stop[i],
                       held_width[i]);
          end
        end
        held_count = 0;
        add_record(ROLE_MATCH, line_no, start, stop, width);
        after_left = after_setting;
      end else begin
        if (depth > 0) begin
          while (held_count >= depth) begin
            for (i = 1; i < held_count; i++) begin
              held_start[i-1] = held_start[i];
              held_stop[i-1] = held_stop[i];
              held_line[i-1] = held_line[i];
              held_width[i-1] = held_width[i];
            end
            held_count--;
          end
          held_start[held_count] = start;
          held_stop[held_count] = stop;
          held_line[held_count] = line_no;
          held_width[held_count] = width;
          held_count++;
        end
        if (after_left > 0) begin
          if (is_fresh(line_no)) add_record(ROLE_CONTEXT, line_no, start, stop, width);
          after_left--;
        end
      end
      if (expected_records.size() > first) begin
        tail = expected_records.pop_back();
        tail.last = 1'b1;
        expected_records = {expected_records, tail};
      end
      line_no++;
      next_start = stop;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_record(record_t got);
      record_t want;
      if (expected_records.size() == 0) begin
        $display("%0t unexpected record: expected none, actual line %0d", $time,
                 got.line_index);
        mismatches++;
        return;
      end
      want = expected_records.pop_front();
      compare_field("role", 64'(want.role), 64'(got.role));
      compare_field("line_index", 64'(want.line_index), 64'(got.line_index));
      compare_field("line_start", 64'(want.line_start), 64'(got.line_start));
      compare_field("line_stop", 64'(want.line_stop), 64'(got.line_stop));
      compare_field("line_width", 64'(want.line_width), 64'(got.line_width));
      compare_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

endpackage

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench that drives the context line emitter and checks its records.
module tb_top;
  import gcle_pkg::*;
  import gcle_tb_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 30;

  typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_RARE} ready_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_index = 1'b0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              new_file = 1'b0;
  logic              is_match = 1'b0;
  logic [OFF_W-1:0]  line_end = '0;
  logic [LEN_W-1:0]  line_length = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              role;
  logic [LINE_W-1:0] line_index;
  logic [OFF_W-1:0]  line_start;
  logic [OFF_W-1:0]  line_stop;
  logic [LEN_W-1:0]  line_width;
  logic              last;

  context_scoreboard sb = new();
  int unsigned       idle_cycles = 0;
  int unsigned       burst_left = 0;
  logic [OFF_W-1:0]  file_pos = '0;
  bit                hold_go = 1'b0;
  bit                hold_done = 1'b0;
  int unsigned       hold_count = 0;
  ready_mode_t       ready_mode = READY_ALWAYS;
  int unsigned       mode_left = 0;

  grep_context_line_emitter dut (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic write_register(logic index, logic [CFG_W-1:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = index;
    cfg_data = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_register(index, data);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (sb.expected_records.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_line(logic nf, logic m, logic [OFF_W-1:0] stop_at,
                           logic [LEN_W-1:0] width);
    new_file = nf;
    is_match = m;
    line_end = stop_at;
    line_length = width;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_line(nf, m, stop_at, width);
    @(negedge clk);
  endtask

  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  task automatic send_random_line(int unsigned match_pct);
    logic nf;
    logic m;
    logic [OFF_W-1:0] stop_at;
    logic [LEN_W-1:0] width;
    logic [63:0] wide;
    nf = ($urandom_range(0, 39) == 0);
    m = ($urandom_range(0, 99) < match_pct);
    wide = {$urandom, $urandom};
    if (nf) file_pos = '0;
    case ($urandom_range(0, 15))
      0: stop_at = '0;
      1: stop_at = '1;
      2, 3: stop_at = wide[OFF_W-1:0];
      default: stop_at = file_pos + OFF_W'($urandom_range(1, 200));
    endcase
    file_pos = stop_at;
    case ($urandom_range(0, 7))
      0: width = '0;
      1: width = '1;
      2: width = LEN_W'($urandom);
      default: width = LEN_W'($urandom_range(0, 160));
    endcase
    pace();
    send_line(nf, m, stop_at, width);
  endtask

  task automatic run_phase(logic [BEF_W-1:0] before_depth, logic [AFT_W-1:0] after_count,
                           int unsigned match_pct, int unsigned count, bit hold);
    settle();
    write_register(REG_BEFORE, CFG_W'(before_depth));
    write_register(REG_AFTER, CFG_W'(after_count));
    if (hold) hold_go = 1'b1;
    repeat (count) send_random_line(match_pct);
  endtask

  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      out_ready = 1'b0;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 150);
      end
      mode_left--;
      case (ready_mode)
        READY_ALWAYS: out_ready = 1'b1;
        READY_HALF: out_ready = 1'($urandom_range(0, 1));
        READY_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
        default: out_ready = ($urandom_range(0, 11) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_record({role, line_index, line_start, line_stop, line_width, last});
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int k;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // A before depth above the ring size saturates, so the match flushes eight lines.
    write_register(REG_BEFORE, 16'd15);
    write_register(REG_AFTER, 16'd2);
    send_line(1'b1, 1'b0, 48'd10, 24'd0);
    for (k = 1; k <= 8; k++) send_line(1'b0, 1'b0, OFF_W'(10 * k + 10), LEN_W'(k));
    send_line(1'b0, 1'b1, '1, '1);
    send_line(1'b0, 1'b0, '0, '1);
    send_line(1'b0, 1'b1, 48'd40, 24'd7);
    send_line(1'b0, 1'b0, 48'd50, 24'd3);
    send_line(1'b0, 1'b0, 48'd60, 24'd3);
    send_line(1'b0, 1'b0, 48'd70, 24'd3);

    // Lowering the depth mid-file trims the ring on the next insertion.
    settle();
    write_register(REG_BEFORE, 16'd2);
    write_register(REG_AFTER, 16'd0);
    send_line(1'b0, 1'b0, 48'd80, 24'd1);
    send_line(1'b0, 1'b1, 48'd90, 24'd2);

    settle();
    write_register(REG_BEFORE, 16'd0);
    write_register(REG_AFTER, 16'd1);
    send_line(1'b0, 1'b0, 48'd100, 24'd4);
    send_line(1'b0, 1'b1, 48'd110, 24'd5);
    send_line(1'b0, 1'b0, 48'd120, 24'd6);
    send_line(1'b1, 1'b0, 48'd5, 24'd6);
    send_line(1'b1, 1'b1, 48'd9, 24'd0);
    file_pos = 48'd9;

    run_phase(4'd0, 16'd0, 30, 60, 1'b0);
    run_phase(4'd8, 16'hFFFF, 10, 80, 1'b1);
    run_phase(4'd1, 16'd1, 25, 70, 1'b0);
    run_phase(4'd15, 16'd3, 20, 80, 1'b0);
    repeat (2) begin
      run_phase(BEF_W'($urandom_range(0, 15)), AFT_W'($urandom_range(0, 9)),
                $urandom_range(5, 40), 80, 1'b0);
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/gcle_pkg.sv
src/gcle_cell.sv
src/gcle_out.sv
src/grep_context_line_emitter.sv
dv/gcle_tb_pkg.sv
dv/tb_top.sv
